// File: rtl/core/rto_pkg.sv
`timescale 1ns / 1ps

package rto_pkg;

  // Item kinds carried on the action field. Code 3 is unused and acts as a query.
  typedef enum logic [1:0] {
    ACT_SAMPLE  = 2'd0,
    ACT_TIMEOUT = 2'd1,
    ACT_QUERY   = 2'd2
  } action_t;

  // Configuration register indexes.
  localparam logic [0:0] REG_RTO_MIN = 1'b0;
  localparam logic [0:0] REG_RTO_MAX = 1'b1;

  // Widths of the estimator state and fields.
  localparam int unsigned StateW = 20;
  localparam int unsigned RttW   = 16;
  localparam int unsigned RtoW   = 32;

  // Reset values.
  localparam logic [StateW-1:0] RTO_MIN_RESET = 20'd1000;
  localparam logic [StateW-1:0] RTO_MAX_RESET = 20'd3000;
  localparam logic [StateW-1:0] SRTT_RESET    = 20'd0;
  localparam logic [StateW-1:0] RTTVAR_RESET  = 20'd3000;
  localparam logic [RtoW-1:0]   RTO_RESET     = 32'd3000;

  // Saturation limit of the scaled state registers.
  localparam logic [StateW-1:0] STATE_MAX = 20'hFFFFF;

endpackage

// File: rtl/core/retransmit_timeout_estimator.sv
`timescale 1ns / 1ps

// An item's result is presented in the cycle after its input transfer. One item per
// cycle unless a held result stalls input; the state update is a single registered
// pass (subtract, absolute value, adds, saturate, clamp) between input and result.
// Reset (rst, synchronous): srtt = 0, rttvar = 3000, RTO = 3000, rto_min = 1000,
// rto_max = 3000, no result pending.
module retransmit_timeout_estimator (
  input  logic        clk,
  input  logic        rst,
  // Input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] rtt_ms,
  // Results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] rto_ms,
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  logic [rto_pkg::StateW-1:0] rto_min;
  logic [rto_pkg::StateW-1:0] rto_max;
  logic [rto_pkg::StateW-1:0] srtt_scaled;
  logic [rto_pkg::StateW-1:0] rttvar_scaled;
  logic [rto_pkg::RtoW-1:0]   rto_current;

  logic                       in_xfer;
  logic [16:0]                srtt_div;
  logic signed [17:0]         delta;
  logic [16:0]                mag;
  logic signed [21:0]         srtt_sum;
  logic [rto_pkg::StateW-1:0] srtt_next;
  logic [rto_pkg::StateW-1:0] rttvar_dec;
  logic [20:0]                rttvar_sum;
  logic [rto_pkg::StateW-1:0] rttvar_next;
  logic [20:0]                rto_raw;
  logic [20:0]                rto_clamped;
  logic [rto_pkg::RtoW-1:0]   rto_doubled;
  logic [rto_pkg::RtoW-1:0]   rto_next;

  // Handshake: a new item enters whenever the result slot is free or being emptied.
  assign in_ready  = !out_valid || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign rto_ms    = rto_current;

  // Error term between the new sample and the smoothed estimate.
  always_comb begin
    srtt_div = srtt_scaled[rto_pkg::StateW-1:3];
    delta    = $signed({2'b00, rtt_ms}) - $signed({1'b0, srtt_div});
    mag      = delta[17] ? 17'(-delta) : delta[16:0];
  end

  // Smoothed RTT update with saturation to the 20-bit range.
  always_comb begin
    srtt_sum = $signed({2'b00, srtt_scaled}) + 22'(delta);
    if (srtt_sum < 0) begin
      srtt_next = '0;
    end else if (srtt_sum > $signed({2'b00, rto_pkg::STATE_MAX})) begin
      srtt_next = rto_pkg::STATE_MAX;
    end else begin
      srtt_next = srtt_sum[rto_pkg::StateW-1:0];
    end
  end

  // Variance update; the decayed term never goes negative, so only the top saturates.
  always_comb begin
    rttvar_dec = rttvar_scaled - {2'b00, rttvar_scaled[rto_pkg::StateW-1:2]};
    rttvar_sum = {1'b0, rttvar_dec} + {4'b0000, mag};
    rttvar_next = rttvar_sum[20] ? rto_pkg::STATE_MAX : rttvar_sum[rto_pkg::StateW-1:0];
  end

  // Recomputed RTO, clamped low first and then high.
  always_comb begin
    rto_raw = {4'b0000, srtt_next[rto_pkg::StateW-1:3]} + {1'b0, rttvar_next};
    if (rto_raw < {1'b0, rto_min}) begin
      rto_clamped = {1'b0, rto_min};
    end else if (rto_raw > {1'b0, rto_max}) begin
      rto_clamped = {1'b0, rto_max};
    end else begin
      rto_clamped = rto_raw;
    end
  end

  // Backoff doubling saturates at the top of the 32-bit range.
  assign rto_doubled = rto_current[rto_pkg::RtoW-1] ? '1 : {rto_current[rto_pkg::RtoW-2:0], 1'b0};

  // Select the new RTO for the item kind.
  always_comb begin
    case (action)
      rto_pkg::ACT_SAMPLE:  rto_next = {11'd0, rto_clamped};
      rto_pkg::ACT_TIMEOUT: rto_next = rto_doubled;
      default:              rto_next = rto_current;
    endcase
  end

  // Estimator state; it moves only on an input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      srtt_scaled   <= rto_pkg::SRTT_RESET;
      rttvar_scaled <= rto_pkg::RTTVAR_RESET;
      rto_current   <= rto_pkg::RTO_RESET;
    end else if (in_xfer) begin
      rto_current <= rto_next;
      if (action == rto_pkg::ACT_SAMPLE) begin
        srtt_scaled   <= srtt_next;
        rttvar_scaled <= rttvar_next;
      end
    end
  end

  // Result slot: filled by an input transfer, emptied by an output transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Clamp registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rto_min <= rto_pkg::RTO_MIN_RESET;
      rto_max <= rto_pkg::RTO_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rto_pkg::REG_RTO_MIN: rto_min <= cfg_data;
        rto_pkg::REG_RTO_MAX: rto_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // A query, or the unused code, leaves the RTO unchanged and produces a result.
  a_query_holds: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && action != rto_pkg::ACT_SAMPLE && action != rto_pkg::ACT_TIMEOUT)
      |=> (out_valid && rto_ms == $past(rto_ms)))
    else $error("query item changed the RTO");

  // A timeout never lowers the RTO.
  a_timeout_grows: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && action == rto_pkg::ACT_TIMEOUT) |=> (rto_ms >= $past(rto_ms)))
    else $error("timeout item lowered the RTO");

  // With consistent bounds, a sample leaves the RTO inside them.
  a_sample_clamped: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && action == rto_pkg::ACT_SAMPLE && rto_min <= rto_max)
      |=> (rto_ms >= {12'd0, $past(rto_min)} && rto_ms <= {12'd0, $past(rto_max)}))
    else $error("sample RTO outside clamp bounds");

endmodule

// File: sim/tb_retransmit_timeout_estimator.sv
`timescale 1ns / 1ps

module tb_retransmit_timeout_estimator;

  // The unused action code, which the block treats as a query.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [19:0] CFG_TOP = 20'hFFFFF;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  act;
    logic [15:0] rtt;
  } rtt_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = rto_pkg::ACT_QUERY;
  logic [15:0] rtt_ms = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] rto_ms;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = rto_pkg::REG_RTO_MIN;
  logic [19:0] cfg_data = 20'd0;

  // Items waiting to be sent and RTO values waiting to come back.
  rtt_item_t   item_q[$];
  logic [31:0] rto_due[$];

  // Estimator state and clamp registers as the testbench tracks them.
  logic [19:0] m_srtt;
  logic [19:0] m_rttvar;
  logic [31:0] m_rto;
  logic [19:0] m_lo;
  logic [19:0] m_hi;

  int unsigned n_errors = 0;
  int unsigned cycles = 0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  int unsigned steady_left = 0;
  logic        steady = 1'b0;
  logic        in_busy;
  rtt_item_t   next_item;
  logic [31:0] want_rto;

  retransmit_timeout_estimator u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .rtt_ms    (rtt_ms),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rto_ms    (rto_ms),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Saturate a scaled state value to the 20-bit range.
  function automatic logic [19:0] clip_state(longint v);
    if (v < 0) return 20'd0;
    if (v > longint'(rto_pkg::STATE_MAX)) return rto_pkg::STATE_MAX;
    return v[19:0];
  endfunction

  // Advance the tracked estimator by one item and return the RTO it reports.
  function automatic logic [31:0] predict_rto(logic [1:0] act, logic [15:0] rtt);
    longint delta;
    longint mag;
    logic [31:0] raw;
    case (act)
      rto_pkg::ACT_SAMPLE: begin
        delta = longint'(rtt) - longint'(m_srtt >> 3);
        mag = (delta < 0) ? -delta : delta;
        m_srtt = clip_state(longint'(m_srtt) + delta);
        m_rttvar = clip_state(longint'(m_rttvar) + mag - longint'(m_rttvar >> 2));
        raw = 32'(m_srtt >> 3) + 32'(m_rttvar);
        // Low clamp wins over the high clamp when the two bounds cross.
        if (raw < 32'(m_lo)) m_rto = 32'(m_lo);
        else if (raw > 32'(m_hi)) m_rto = 32'(m_hi);
        else m_rto = raw;
      end
      rto_pkg::ACT_TIMEOUT: begin
        m_rto = (m_rto > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : (m_rto << 1);
      end
      default: begin
      end
    endcase
    return m_rto;
  endfunction

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (n_errors < 40)
      $display("MISMATCH cycle %0d: %s: rto_ms got %0d, expected %0d",
               cycles, what, got, want);
    n_errors++;
  endtask

  // Stretches in which neither side idles.
  always @(posedge clk) begin
    if (steady_left != 0) begin
      steady_left <= steady_left - 1;
      steady <= 1'b1;
    end else begin
      steady <= 1'b0;
      if ($urandom_range(0, 99) < 3) steady_left <= $urandom_range(20, 80);
    end
  end

  // Input driver: predicts the RTO for every accepted transfer.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
      m_srtt = rto_pkg::SRTT_RESET;
      m_rttvar = rto_pkg::RTTVAR_RESET;
      m_rto = rto_pkg::RTO_RESET;
      m_lo = rto_pkg::RTO_MIN_RESET;
      m_hi = rto_pkg::RTO_MAX_RESET;
    end else begin
      in_busy = in_valid;
      if (in_valid && in_ready) begin
        rto_due.push_back(predict_rto(action, rtt_ms));
        in_busy = 1'b0;
      end
      if (!in_busy) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (item_q.size() != 0) begin
          next_item = item_q.pop_front();
          action <= next_item.act;
          rtt_ms <= next_item.rtt;
          in_valid <= 1'b1;
          in_gap = steady ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each result transfer with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (rto_due.size() == 0) begin
          report_mismatch("result with nothing expected", rto_ms, 32'd0);
        end else begin
          want_rto = rto_due.pop_front();
          if (rto_ms !== want_rto) report_mismatch("wrong RTO", rto_ms, want_rto);
        end
      end
      if (out_stall != 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_stall = steady ? 0 : pick_gap();
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic add_item(logic [1:0] act, logic [15:0] rtt);
    rtt_item_t it;
    it.act = act;
    it.rtt = rtt;
    item_q.push_back(it);
  endtask

  // Wait until every item is sent and every result is back, then let the
  // pipeline settle before touching the registers.
  task automatic wait_idle();
    do @(posedge clk);
    while (item_q.size() != 0 || in_valid || rto_due.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [19:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == rto_pkg::REG_RTO_MIN) m_lo = val;
    else m_hi = val;
  endtask

  task automatic set_bounds(logic [19:0] lo, logic [19:0] hi);
    wait_idle();
    write_reg(rto_pkg::REG_RTO_MIN, lo);
    write_reg(rto_pkg::REG_RTO_MAX, hi);
  endtask

  // Random traffic: samples that wander around a level, sometimes jump or hit
  // the extremes, timeouts alone or in long runs, and queries.
  task automatic add_random(int n);
    int k;
    int r;
    int burst;
    int level;
    int v;
    k = 0;
    level = $urandom_range(0, 4000);
    while (k < n) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        if ($urandom_range(0, 19) == 0) level = $urandom_range(0, 65535);
        case ($urandom_range(0, 3))
          0: v = $urandom_range(0, 65535);
          1: v = level + $urandom_range(0, 128) - 64;
          2: v = $urandom_range(0, 255);
          default: v = ($urandom_range(0, 1) != 0) ? 65535 : 0;
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        add_item(rto_pkg::ACT_SAMPLE, 16'(v));
        k++;
      end else if (r < 80) begin
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : 1;
        repeat (burst) add_item(rto_pkg::ACT_TIMEOUT, 16'($urandom_range(0, 65535)));
        k += burst;
      end else if (r < 93) begin
        add_item(rto_pkg::ACT_QUERY, 16'($urandom_range(0, 65535)));
        k++;
      end else begin
        add_item(ACT_UNUSED, 16'($urandom_range(0, 65535)));
        k++;
      end
    end
  endtask

  initial begin
    // Reset bounds: queries at reset, unused code, extreme samples, timeouts.
    add_item(rto_pkg::ACT_QUERY, 16'd0);
    add_item(ACT_UNUSED, 16'hFFFF);
    add_item(rto_pkg::ACT_SAMPLE, 16'd0);
    add_item(rto_pkg::ACT_SAMPLE, 16'hFFFF);
    add_item(rto_pkg::ACT_SAMPLE, 16'hFFFF);
    add_item(rto_pkg::ACT_TIMEOUT, 16'd0);
    add_item(rto_pkg::ACT_TIMEOUT, 16'hFFFF);
    add_item(rto_pkg::ACT_QUERY, 16'hFFFF);
    add_item(rto_pkg::ACT_SAMPLE, 16'd0);
    add_item(rto_pkg::ACT_SAMPLE, 16'd1);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Crossed bounds at the extremes, then timeouts up to saturation.
    set_bounds(CFG_TOP, 20'd0);
    add_item(rto_pkg::ACT_SAMPLE, 16'd500);
    repeat (13) add_item(rto_pkg::ACT_TIMEOUT, 16'd0);
    add_item(rto_pkg::ACT_QUERY, 16'd0);

    set_bounds(20'd1000, 20'd3000);
    add_random(140);
    set_bounds(20'd0, 20'd0);
    add_random(140);
    set_bounds(20'd0, CFG_TOP);
    add_random(140);
    set_bounds(20'd200, 20'd400);
    add_random(140);
    set_bounds(20'($urandom_range(0, 3000)), 20'($urandom_range(3001, 1048575)));
    add_random(140);
    set_bounds(20'($urandom_range(5000, 1048575)), 20'($urandom_range(0, 4999)));
    add_random(140);
    set_bounds(CFG_TOP, CFG_TOP);
    add_random(140);

    wait_idle();
    repeat (4) @(posedge clk);
    if (rto_due.size() != 0) report_mismatch("result never arrived", 32'd0, rto_due[0]);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
